// File: rtl/pba_pkg.sv
// Shared widths, latencies, control struct and arctangent table for the bearing core.
`default_nettype none

package pba_pkg;

    localparam int COORD_W       = 24;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int MAG_W         = COORD_W;

    localparam int CORDIC_STAGES = 16;
    localparam int GUARD_W       = 32;
    localparam int CORDIC_W      = MAG_W + GUARD_W + 4;
    localparam int ATAN_W        = 25;
    localparam int TAB_IDX_W     = 5;

    localparam int ROOT_W        = 25;
    localparam int SQ_W          = 2 * ROOT_W;
    localparam int REM_W         = ROOT_W + 1;
    localparam int DIST_W        = 25;

    localparam int ANGLE_W       = 16;
    localparam int T_W           = 23;
    localparam int FULL_W        = 25;
    localparam int ANGLE_SHIFT   = 9;
    localparam int ROUND_HALF    = 1 << (ANGLE_SHIFT - 1);

    localparam int DEG_ONE       = 65536;
    localparam int DEG_45        = 45 * DEG_ONE;
    localparam int DEG_90        = 90 * DEG_ONE;
    localparam int DEG_180       = 180 * DEG_ONE;
    localparam int DEG_360       = 360 * DEG_ONE;
    localparam int ANGLE_FULL    = DEG_360 >> ANGLE_SHIFT;

    localparam int ANG_LAT       = CORDIC_STAGES + 2;
    localparam int DIST_LAT      = ROOT_W + 3;
    localparam int PIPE_LAT      = (ANG_LAT > DIST_LAT) ? ANG_LAT : DIST_LAT;
    localparam int ANG_PAD       = PIPE_LAT - ANG_LAT;
    localparam int DIST_PAD      = PIPE_LAT - DIST_LAT;

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic on_x_axis;
        logic on_y_axis;
        logic diag;
    } pba_ctl_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = ATAN_W'(2949120);
            5'd1:    v = ATAN_W'(1740967);
            5'd2:    v = ATAN_W'(919879);
            5'd3:    v = ATAN_W'(466945);
            5'd4:    v = ATAN_W'(234379);
            5'd5:    v = ATAN_W'(117304);
            5'd6:    v = ATAN_W'(58666);
            5'd7:    v = ATAN_W'(29335);
            5'd8:    v = ATAN_W'(14668);
            5'd9:    v = ATAN_W'(7334);
            5'd10:   v = ATAN_W'(3667);
            5'd11:   v = ATAN_W'(1833);
            5'd12:   v = ATAN_W'(917);
            5'd13:   v = ATAN_W'(458);
            5'd14:   v = ATAN_W'(229);
            5'd15:   v = ATAN_W'(115);
            5'd16:   v = ATAN_W'(57);
            5'd17:   v = ATAN_W'(29);
            5'd18:   v = ATAN_W'(14);
            5'd19:   v = ATAN_W'(7);
            5'd20:   v = ATAN_W'(4);
            5'd21:   v = ATAN_W'(2);
            5'd22:   v = ATAN_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/point_bearing_angle_core.sv
// Top level: point difference, parallel distance and bearing pipelines, output skid stage.
// Path from an accepted word to result_valid, with 16 CORDIC stages:
//   front stage, 25-bit root pipeline of 28 stages, output register.
// Throughput: one word per cycle; the whole pipeline holds only while the skid stage is full.
// Reset: rst_n clears all valid bits, the output valid flag and the skid flag at once.
`default_nettype none

module point_bearing_angle_core
    import pba_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      pair_valid,
    output logic                           pair_stall,
    input  wire logic signed [COORD_W-1:0] src_x,
    input  wire logic signed [COORD_W-1:0] src_y,
    input  wire logic signed [COORD_W-1:0] dst_x,
    input  wire logic signed [COORD_W-1:0] dst_y,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output logic             [DIST_W-1:0]  distance,
    output logic             [ANGLE_W-1:0] angle,
    output logic                           coincident
);

    logic                      adv;
    logic                      take;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic        [MAG_W-1:0]   ax;
    logic        [MAG_W-1:0]   ay;
    pba_ctl_t                  ctl_next;

    logic        [MAG_W-1:0]   mag_x_reg;
    logic        [MAG_W-1:0]   mag_y_reg;
    pba_ctl_t                  ctl_reg;
    logic                      valid_reg [PIPE_LAT+1];
    logic                      coin_reg  [PIPE_LAT+1];

    logic        [DIST_W-1:0]  dist_raw;
    logic        [ANGLE_W-1:0] angle_raw;
    logic        [DIST_W-1:0]  dist_pipe;
    logic        [ANGLE_W-1:0] angle_pipe;

    logic                      out_valid_reg;
    logic                      skid_valid_reg;
    logic        [DIST_W-1:0]  dist_out_reg;
    logic        [ANGLE_W-1:0] angle_out_reg;
    logic                      coin_out_reg;
    logic        [DIST_W-1:0]  dist_skid_reg;
    logic        [ANGLE_W-1:0] angle_skid_reg;
    logic                      coin_skid_reg;

    assign adv        = !skid_valid_reg;
    assign pair_stall = skid_valid_reg;
    assign take       = out_valid_reg && !result_stall;

    always_comb
    begin
        dx = DIFF_W'(dst_x) - DIFF_W'(src_x);
        dy = DIFF_W'(dst_y) - DIFF_W'(src_y);
        ax = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        ay = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        ctl_next.x_neg     = dx[DIFF_W-1];
        ctl_next.y_neg     = dy[DIFF_W-1];
        ctl_next.on_x_axis = (ay == '0);
        ctl_next.on_y_axis = (ax == '0);
        ctl_next.diag      = (ax == ay);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_x_reg   <= ax;
            mag_y_reg   <= ay;
            ctl_reg     <= ctl_next;
            coin_reg[0] <= (dx == '0) && (dy == '0);
            for (int k = 1; k <= PIPE_LAT; k++)
            begin
                coin_reg[k] <= coin_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= PIPE_LAT; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= pair_valid;
            for (int k = 1; k <= PIPE_LAT; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    pba_isqrt u_isqrt (
        .clk   (clk),
        .en    (adv),
        .mag_x (mag_x_reg),
        .mag_y (mag_y_reg),
        .root  (dist_raw)
    );

    pba_cordic u_cordic (
        .clk   (clk),
        .en    (adv),
        .mag_x (mag_x_reg),
        .mag_y (mag_y_reg),
        .ctl   (ctl_reg),
        .angle (angle_raw)
    );

    // align the shorter path to the longer one
    generate
        if (ANG_PAD > 0)
        begin : g_ang_pad
            logic [ANGLE_W-1:0] pad_reg [ANG_PAD];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pad_reg[0] <= angle_raw;
                    for (int k = 1; k < ANG_PAD; k++)
                    begin
                        pad_reg[k] <= pad_reg[k-1];
                    end
                end
            end
            assign angle_pipe = pad_reg[ANG_PAD-1];
        end
        else
        begin : g_ang_direct
            assign angle_pipe = angle_raw;
        end

        if (DIST_PAD > 0)
        begin : g_dist_pad
            logic [DIST_W-1:0] pad_reg [DIST_PAD];
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pad_reg[0] <= dist_raw;
                    for (int k = 1; k < DIST_PAD; k++)
                    begin
                        pad_reg[k] <= pad_reg[k-1];
                    end
                end
            end
            assign dist_pipe = pad_reg[DIST_PAD-1];
        end
        else
        begin : g_dist_direct
            assign dist_pipe = dist_raw;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (valid_reg[PIPE_LAT])
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                dist_out_reg  <= dist_skid_reg;
                angle_out_reg <= angle_skid_reg;
                coin_out_reg  <= coin_skid_reg;
            end
        end
        else if (valid_reg[PIPE_LAT])
        begin
            if (!out_valid_reg || take)
            begin
                dist_out_reg  <= dist_pipe;
                angle_out_reg <= angle_pipe;
                coin_out_reg  <= coin_reg[PIPE_LAT];
            end
            else
            begin
                dist_skid_reg  <= dist_pipe;
                angle_skid_reg <= angle_pipe;
                coin_skid_reg  <= coin_reg[PIPE_LAT];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign distance     = dist_out_reg;
    assign angle        = angle_out_reg;
    assign coincident   = coin_out_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !result_stall |=> !skid_valid_reg)
        else $error("skid word not moved after output taken");

    a_coincident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && coincident |-> (distance == '0) && (angle == '0))
        else $error("coincident word with nonzero distance or angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (angle < ANGLE_W'(ANGLE_FULL)))
        else $error("angle out of range");

endmodule

`default_nettype wire

// File: rtl/pba_isqrt.sv
// Pipelined distance: squares, sum, one root bit per stage, round to nearest.
`default_nettype none

module pba_isqrt
    import pba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [MAG_W-1:0]  mag_x,
    input  wire logic [MAG_W-1:0]  mag_y,
    output logic      [DIST_W-1:0] root
);

    logic [2*MAG_W-1:0] sqx_reg;
    logic [2*MAG_W-1:0] sqy_reg;
    logic [SQ_W-1:0]    sum_reg;

    logic [SQ_W-1:0]    s_in    [ROOT_W];
    logic [REM_W-1:0]   r_in    [ROOT_W];
    logic [ROOT_W-1:0]  q_in    [ROOT_W];
    logic [REM_W+1:0]   rs      [ROOT_W];
    logic [REM_W+1:0]   trial   [ROOT_W];
    logic               ge      [ROOT_W];
    logic [REM_W-1:0]   r_next  [ROOT_W];
    logic [ROOT_W-1:0]  q_next  [ROOT_W];

    logic [SQ_W-1:0]    s_reg   [ROOT_W];
    logic [REM_W-1:0]   r_reg   [ROOT_W];
    logic [ROOT_W-1:0]  q_reg   [ROOT_W];
    logic [DIST_W-1:0]  root_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= mag_x * mag_x;
            sqy_reg <= mag_y * mag_y;
            sum_reg <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
        end
    end

    always_comb
    begin
        s_in[0] = sum_reg;
        r_in[0] = '0;
        q_in[0] = '0;
        for (int i = 1; i < ROOT_W; i++)
        begin
            s_in[i] = s_reg[i-1];
            r_in[i] = r_reg[i-1];
            q_in[i] = q_reg[i-1];
        end
    end

    // restoring square root, two radicand bits per stage
    always_comb
    begin
        for (int i = 0; i < ROOT_W; i++)
        begin
            rs[i]     = {r_in[i], s_in[i][SQ_W-1-2*i -: 2]};
            trial[i]  = {1'b0, q_in[i], 2'b01};
            ge[i]     = (rs[i] >= trial[i]);
            r_next[i] = ge[i] ? REM_W'(rs[i] - trial[i]) : REM_W'(rs[i]);
            q_next[i] = {q_in[i][ROOT_W-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                s_reg[i] <= s_in[i];
                r_reg[i] <= r_next[i];
                q_reg[i] <= q_next[i];
            end
            if (r_reg[ROOT_W-1] > REM_W'(q_reg[ROOT_W-1]))
            begin
                root_reg <= DIST_W'(q_reg[ROOT_W-1] + 1'b1);
            end
            else
            begin
                root_reg <= DIST_W'(q_reg[ROOT_W-1]);
            end
        end
    end

    assign root = root_reg;

endmodule

`default_nettype wire

// File: rtl/pba_cordic.sv
// Pipelined CORDIC vectoring unit with special cases, quadrant fold and angle rounding.
`default_nettype none

module pba_cordic
    import pba_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [MAG_W-1:0]   mag_x,
    input  wire logic [MAG_W-1:0]   mag_y,
    input  wire pba_ctl_t           ctl,
    output logic      [ANGLE_W-1:0] angle
);

    logic signed [CORDIC_W-1:0] x_in   [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] y_in   [CORDIC_STAGES];
    logic signed [ATAN_W-1:0]   z_in   [CORDIC_STAGES];
    pba_ctl_t                   c_in   [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] x_next [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] y_next [CORDIC_STAGES];
    logic signed [ATAN_W-1:0]   z_next [CORDIC_STAGES];

    logic signed [CORDIC_W-1:0] x_reg  [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] y_reg  [CORDIC_STAGES];
    logic signed [ATAN_W-1:0]   z_reg  [CORDIC_STAGES];
    pba_ctl_t                   c_reg  [CORDIC_STAGES];

    logic signed [ATAN_W-1:0]   z_last;
    pba_ctl_t                   c_last;
    logic [T_W-1:0]             t_next;
    logic [T_W-1:0]             t_reg;
    pba_ctl_t                   t_ctl_reg;
    logic [FULL_W-1:0]          full;
    logic [FULL_W:0]            biased;
    logic [FULL_W-ANGLE_SHIFT:0] rounded;
    logic [ANGLE_W-1:0]         angle_next;
    logic [ANGLE_W-1:0]         angle_reg;

    always_comb
    begin
        x_in[0] = CORDIC_W'({mag_x, {GUARD_W{1'b0}}});
        y_in[0] = CORDIC_W'({mag_y, {GUARD_W{1'b0}}});
        z_in[0] = '0;
        c_in[0] = ctl;
        for (int i = 1; i < CORDIC_STAGES; i++)
        begin
            x_in[i] = x_reg[i-1];
            y_in[i] = y_reg[i-1];
            z_in[i] = z_reg[i-1];
            c_in[i] = c_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (!y_in[i][CORDIC_W-1])
            begin
                x_next[i] = x_in[i] + (y_in[i] >>> i);
                y_next[i] = y_in[i] - (x_in[i] >>> i);
                z_next[i] = z_in[i] + $signed(atan_entry(TAB_IDX_W'(i)));
            end
            else
            begin
                x_next[i] = x_in[i] - (y_in[i] >>> i);
                y_next[i] = y_in[i] + (x_in[i] >>> i);
                z_next[i] = z_in[i] - $signed(atan_entry(TAB_IDX_W'(i)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
                c_reg[i] <= c_in[i];
            end
        end
    end

    assign z_last = z_reg[CORDIC_STAGES-1];
    assign c_last = c_reg[CORDIC_STAGES-1];

    // first-quadrant angle: axis and diagonal cases override, else clamp to 0..90
    always_comb
    begin
        if (c_last.on_x_axis)
        begin
            t_next = '0;
        end
        else if (c_last.on_y_axis)
        begin
            t_next = T_W'(DEG_90);
        end
        else if (c_last.diag)
        begin
            t_next = T_W'(DEG_45);
        end
        else if (z_last[ATAN_W-1])
        begin
            t_next = '0;
        end
        else if (z_last[ATAN_W-2:0] > (ATAN_W-1)'(DEG_90))
        begin
            t_next = T_W'(DEG_90);
        end
        else
        begin
            t_next = T_W'(z_last);
        end
    end

    always_comb
    begin
        if (!t_ctl_reg.x_neg && !t_ctl_reg.y_neg)
        begin
            full = FULL_W'(t_reg);
        end
        else if (t_ctl_reg.x_neg && !t_ctl_reg.y_neg)
        begin
            full = FULL_W'(DEG_180) - FULL_W'(t_reg);
        end
        else if (t_ctl_reg.x_neg)
        begin
            full = FULL_W'(DEG_180) + FULL_W'(t_reg);
        end
        else
        begin
            full = FULL_W'(DEG_360) - FULL_W'(t_reg);
        end
        biased  = (FULL_W+1)'(full) + (FULL_W+1)'(ROUND_HALF);
        rounded = biased[FULL_W:ANGLE_SHIFT];
        if (rounded >= (FULL_W-ANGLE_SHIFT+1)'(ANGLE_FULL))
        begin
            angle_next = ANGLE_W'(rounded - (FULL_W-ANGLE_SHIFT+1)'(ANGLE_FULL));
        end
        else
        begin
            angle_next = ANGLE_W'(rounded);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next;
            t_ctl_reg <= c_last;
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for point_bearing_angle_core: predicts distance and bearing per word.
`timescale 1ns / 100ps

module testbench
    import pba_pkg::*;
();

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int GUARD       = 32;
    localparam int STEP_LIMIT  = 32;

    localparam logic signed [COORD_W-1:0] C_MAX = 24'h7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 24'h800000;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [ANGLE_W-1:0] angle;
        logic               coincident;
    } bearing_t;

    logic                       clk;
    logic                       rst_n;
    logic                       pair_valid;
    logic                       pair_stall;
    logic signed [COORD_W-1:0]  src_x;
    logic signed [COORD_W-1:0]  src_y;
    logic signed [COORD_W-1:0]  dst_x;
    logic signed [COORD_W-1:0]  dst_y;
    logic                       result_valid;
    logic                       result_stall;
    logic [DIST_W-1:0]          distance;
    logic [ANGLE_W-1:0]         angle;
    logic                       coincident;

    bearing_t expected_bearings[$];
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_pending;
    bit       failed;
    int       cycle_count;

    point_bearing_angle_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .src_x        (src_x),
        .src_y        (src_y),
        .dst_x        (dst_x),
        .dst_y        (dst_y),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .distance     (distance),
        .angle        (angle),
        .coincident   (coincident)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // atan(2^-i) in 1/65536 degree
    function automatic longint atan_step(input int i);
        case (i)
            0:       return 2949120;
            1:       return 1740967;
            2:       return 919879;
            3:       return 466945;
            4:       return 234379;
            5:       return 117304;
            6:       return 58666;
            7:       return 29335;
            8:       return 14668;
            9:       return 7334;
            10:      return 3667;
            11:      return 1833;
            12:      return 917;
            13:      return 458;
            14:      return 229;
            15:      return 115;
            16:      return 57;
            17:      return 29;
            18:      return 14;
            19:      return 7;
            20:      return 4;
            21:      return 2;
            22:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint unsigned rounded_root(input longint unsigned s);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = s;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > s)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (rem > root)
            root = root + 1;
        return root;
    endfunction

    // first-quadrant angle in 1/65536 degree, ax and ay not both zero
    function automatic longint quadrant_deg(input longint ax, input longint ay);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int     i;
        if (ay == 0)
            return 0;
        if (ax == 0)
            return longint'(DEG_90);
        if (ax == ay)
            return longint'(DEG_45);
        x = ax <<< GUARD;
        y = ay <<< GUARD;
        z = 0;
        for (i = 0; i < CORDIC_STAGES && i < STEP_LIMIT; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(DEG_90))
            z = longint'(DEG_90);
        return z;
    endfunction

    function automatic bearing_t predict_bearing(
        input logic signed [COORD_W-1:0] sx,
        input logic signed [COORD_W-1:0] sy,
        input logic signed [COORD_W-1:0] tx,
        input logic signed [COORD_W-1:0] ty
    );
        bearing_t        r;
        longint          dx;
        longint          dy;
        longint          ax;
        longint          ay;
        longint          t;
        longint          full;
        longint unsigned ang;
        dx = longint'(tx) - longint'(sx);
        dy = longint'(ty) - longint'(sy);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (dx == 0 && dy == 0)
        begin
            r.distance   = '0;
            r.angle      = '0;
            r.coincident = 1'b1;
            return r;
        end
        r.distance = DIST_W'(rounded_root(longint'(ax * ax) + longint'(ay * ay)));
        t = quadrant_deg(ax, ay);
        if (dx >= 0 && dy >= 0)
            full = t;
        else if (dx < 0 && dy >= 0)
            full = longint'(DEG_180) - t;
        else if (dx < 0)
            full = longint'(DEG_180) + t;
        else
            full = longint'(DEG_360) - t;
        ang = (longint'(full) + ROUND_HALF) >> ANGLE_SHIFT;
        if (ang >= ANGLE_FULL)
            ang = ang - ANGLE_FULL;
        r.angle      = ANGLE_W'(ang);
        r.coincident = 1'b0;
        return r;
    endfunction

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_pair(
        input logic signed [COORD_W-1:0] sx,
        input logic signed [COORD_W-1:0] sy,
        input logic signed [COORD_W-1:0] tx,
        input logic signed [COORD_W-1:0] ty
    );
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair_valid <= 1'b1;
        src_x      <= sx;
        src_y      <= sy;
        dst_x      <= tx;
        dst_y      <= ty;
        @(posedge clk);
        while (pair_stall)
            @(posedge clk);
        expected_bearings.push_back(predict_bearing(sx, sy, tx, ty));
    endtask

    function automatic logic signed [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            3:       return '1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] small_delta();
        logic signed [COORD_W-1:0] d;
        d = COORD_W'($urandom_range(0, 255));
        return $urandom_range(0, 1) ? -d : d;
    endfunction

    task automatic send_random_pair();
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic signed [COORD_W-1:0] d;
        sx = COORD_W'($urandom);
        sy = COORD_W'($urandom);
        tx = COORD_W'($urandom);
        ty = COORD_W'($urandom);
        case ($urandom_range(0, 9))
            4, 5:
            begin
                tx = sx + small_delta();
                ty = sy + small_delta();
            end
            6:
            begin
                if ($urandom_range(0, 1))
                    tx = sx;
                else
                    ty = sy;
            end
            7:
            begin
                d  = ($urandom_range(0, 1)) ? small_delta() : COORD_W'($urandom) >>> 2;
                tx = sx + d;
                ty = $urandom_range(0, 1) ? sy + d : sy - d;
            end
            8:
            begin
                tx = sx;
                ty = sy;
            end
            9:
            begin
                sx = pick_extreme();
                sy = pick_extreme();
                tx = pick_extreme();
                ty = pick_extreme();
            end
            default: ;
        endcase
        send_pair(sx, sy, tx, ty);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pair(0, 0, 0, 0);
        send_pair(C_MIN, C_MAX, C_MIN, C_MAX);
        send_pair('1, '1, '1, '1);
        send_pair(0, 0, 100, 0);
        send_pair(0, 0, -100, 0);
        send_pair(0, 0, 0, 100);
        send_pair(0, 0, 0, -100);
        send_pair(0, 0, 256, 256);
        send_pair(0, 0, -256, 256);
        send_pair(0, 0, -256, -256);
        send_pair(0, 0, 256, -256);
        send_pair(C_MIN, 0, C_MAX, 0);
        send_pair(C_MAX, 0, C_MIN, 0);
        send_pair(0, C_MIN, 0, C_MAX);
        send_pair(0, C_MAX, 0, C_MIN);
        send_pair(C_MIN, C_MIN, C_MAX, C_MAX);
        send_pair(C_MAX, C_MAX, C_MIN, C_MIN);
        send_pair(C_MIN, C_MAX, C_MAX, C_MIN);
        send_pair(C_MAX, C_MIN, C_MIN, C_MAX);
        // just below 360 rounds up and wraps to zero
        send_pair(0, 0, C_MAX, -1);
        send_pair(0, 0, -C_MAX, -1);
        send_pair(0, 0, 1, 2);
        send_pair(0, 0, 2, 1);
        send_pair(5, -7, -3, 9);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
            send_random_pair();
    endtask

    task automatic test_backpressure();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pending   = 1'b1;
        for (n = 0; n < 100; n++)
            send_random_pair();
    endtask

    initial
    begin
        int held;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                begin
                    result_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        bearing_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_bearings.size() == 0)
            begin
                $error("unexpected result word: distance %0d angle %0d coincident %0d",
                       distance, angle, coincident);
                failed = 1'b1;
            end
            else
            begin
                want = expected_bearings.pop_front();
                if (distance !== want.distance)
                begin
                    $error("distance: expected %0d, actual %0d", want.distance, distance);
                    failed = 1'b1;
                end
                if (angle !== want.angle)
                begin
                    $error("angle: expected %0d, actual %0d", want.angle, angle);
                    failed = 1'b1;
                end
                if (coincident !== want.coincident)
                begin
                    $error("coincident: expected %0d, actual %0d", want.coincident, coincident);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("point_bearing_angle_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        pair_valid     = 1'b0;
        src_x          = '0;
        src_y          = '0;
        dst_x          = '0;
        dst_y          = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pending   = 1'b0;
        failed         = 1'b0;
        cycle_count    = 0;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 330);
        test_random_phase(59, 0, 330);
        test_random_phase(0, 59, 330);
        test_random_phase(18, 18, 330);
        test_backpressure();
        test_random_phase(0, 0, 30);

        pair_valid     <= 1'b0;
        recv_stall_pct = 0;
        while (expected_bearings.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_LAT + 4) @(posedge clk);

        if (!failed && expected_bearings.size() == 0)
            $display("point_bearing_angle_core regression: pass");
        else
            $display("point_bearing_angle_core regression: fail");
        $finish;
    end

endmodule
